// ===== hdl/kmms_pkg.sv =====
// ----------------------------------------------------------------------------
// kmms_pkg: shared types and constants for the k-way merge minimum selector
// Command codes, key modes, beat structs and controller command/status.
// ----------------------------------------------------------------------------
package kmms_pkg;

    localparam int DEF_NUM_RUNS     = 8;
    localparam int DEF_RECS_PER_RUN = 16;
    localparam int DEF_TEXT_WORDS   = 16;

    localparam logic [1:0] CMD_LOAD_KEY  = 2'd0;
    localparam logic [1:0] CMD_LOAD_TEXT = 2'd1;
    localparam logic [1:0] CMD_ARM       = 2'd2;
    localparam logic [1:0] CMD_POP       = 2'd3;

    localparam logic [1:0] MODE_ID      = 2'd0;
    localparam logic [1:0] MODE_NUM     = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_NUMTEXT = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  run_index;
        logic [3:0]  slot_index;
        logic [3:0]  chunk_index;
        logic [31:0] rec_id;
        logic [31:0] num_key;
        logic [63:0] text_chunk;
    } in_beat_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  win_run;
        logic [3:0]  win_slot;
        logic [31:0] out_id;
        logic [31:0] out_num;
        logic [63:0] out_chunk;
        logic [3:0]  out_chunk_index;
        logic        last;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input beat and run store writes
        logic scan_start;  // reset scan pointer, clear best
        logic rd_head;     // issue reads for current candidate head
        logic rd_chunk;    // issue text read of chunk counter for cand and best
        logic step_chunk;  // evaluate chunk compare result
        logic decide;      // take candidate if less
        logic next_run;    // advance scan pointer
        logic commit;      // advance winner cursor
        logic emit_rd;     // read winner's chunk for output
        logic emit_load;   // load output register
        logic emit_empty;  // load empty result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic cand_ok;     // current run is valid and head in range
        logic have;        // best exists
        logic need_text;   // compare needs text pass
        logic text_done;   // text compare settled
        logic scan_last;   // scan pointer at final run
        logic chunk_last;  // chunk counter at final
    } dp_stat_t;

endpackage

// ===== hdl/kmms_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmms_ctrl: pop sequencer
// Walks the run heads, runs the text compare chunk by chunk, then emits beats.
// ----------------------------------------------------------------------------
module kmms_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               out_busy,
    input  kmms_pkg::dp_stat_t stat,
    output logic               s_ready_o,
    output kmms_pkg::dp_cmd_t  cmd
);
    import kmms_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_DISP  = 10'b0000000010,
        ST_HEAD  = 10'b0000000100,
        ST_CMPK  = 10'b0000001000,
        ST_TRD   = 10'b0000010000,
        ST_TCMP  = 10'b0000100000,
        ST_NEXT  = 10'b0001000000,
        ST_EMRD  = 10'b0010000000,
        ST_EMIT  = 10'b0100000000,
        ST_EMPTY = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready_o = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.capture = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (stat.is_pop) begin
                    cmd.scan_start = 1'b1;
                    state_next = ST_HEAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEAD: begin
                cmd.rd_head = 1'b1;
                state_next = ST_CMPK;
            end
            ST_CMPK: begin
                if (!stat.cand_ok) begin
                    state_next = ST_NEXT;
                end else if (stat.have && stat.need_text) begin
                    state_next = ST_TRD;
                end else begin
                    cmd.decide = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_TRD: begin
                cmd.rd_chunk = 1'b1;
                state_next = ST_TCMP;
            end
            ST_TCMP: begin
                cmd.step_chunk = 1'b1;
                if (stat.text_done || stat.chunk_last) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_TRD;
                end
            end
            ST_NEXT: begin
                if (stat.scan_last) begin
                    if (stat.have) begin
                        cmd.commit = 1'b1;
                        state_next = ST_EMRD;
                    end else begin
                        state_next = ST_EMPTY;
                    end
                end else begin
                    cmd.next_run = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_EMRD: begin
                if (!out_busy) begin
                    cmd.emit_rd = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.emit_load = 1'b1;
                state_next = stat.chunk_last ? ST_IDLE : ST_EMRD;
            end
            ST_EMPTY: begin
                if (!out_busy) begin
                    cmd.emit_empty = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn) $onehot(state_reg))
        else $error("state not one-hot");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load || cmd.emit_empty) |-> !out_busy)
        else $error("emit into occupied output");
    a_cap_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> s_ready_o)
        else $error("capture outside idle");
endmodule

// ===== hdl/kmms_dp.sv =====
// ----------------------------------------------------------------------------
// kmms_dp: stores, run state, key compare and output register
// Key and text memories with registered reads; cursors and valid flags per run.
// ----------------------------------------------------------------------------
module kmms_dp #(
    parameter int NUM_RUNS     = kmms_pkg::DEF_NUM_RUNS,
    parameter int RECS_PER_RUN = kmms_pkg::DEF_RECS_PER_RUN,
    parameter int TEXT_WORDS   = kmms_pkg::DEF_TEXT_WORDS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          key_mode,
    input  kmms_pkg::in_beat_t  in_beat,
    input  kmms_pkg::dp_cmd_t   cmd,
    input  logic                m_ready,
    output kmms_pkg::dp_stat_t  stat,
    output logic                m_valid,
    output kmms_pkg::out_beat_t m_data,
    output logic                out_busy
);
    import kmms_pkg::*;

    localparam int RW   = (NUM_RUNS > 1) ? $clog2(NUM_RUNS) : 1;
    localparam int SW   = (RECS_PER_RUN > 1) ? $clog2(RECS_PER_RUN) : 1;
    localparam int CW   = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;
    localparam int CURW = $clog2(RECS_PER_RUN + 1);
    localparam int NREC = NUM_RUNS * RECS_PER_RUN;
    localparam int AW   = RW + SW;
    localparam int TAW  = AW + CW;

    logic [63:0] key_mem [NREC];
    logic [63:0] txt_mem [NREC * TEXT_WORDS];

    in_beat_t          ib_reg;
    logic [CURW-1:0]   cur_reg [NUM_RUNS];
    logic [NUM_RUNS-1:0] vld_reg;
    logic [RW-1:0]     scan_reg;
    logic [CW-1:0]     chk_reg;
    logic              have_reg;
    logic [RW-1:0]     brun_reg;
    logic [SW-1:0]     bslot_reg;
    logic [63:0]       bkey_reg, ckey_reg;
    logic [63:0]       ta_reg, tb_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    // candidate head of scan run
    logic [CURW-1:0] ccur;
    logic cand_ok;
    logic [SW-1:0] cslot;
    assign ccur    = cur_reg[scan_reg];
    assign cand_ok = vld_reg[scan_reg] && (32'(ccur) < RECS_PER_RUN);
    assign cslot   = ccur[SW-1:0];

    // key memory
    always_ff @(posedge aclk) begin
        if (cmd.capture && in_beat.cmd == CMD_LOAD_KEY
            && 32'(in_beat.run_index) < NUM_RUNS && 32'(in_beat.slot_index) < RECS_PER_RUN)
            key_mem[{in_beat.run_index[RW-1:0], in_beat.slot_index[SW-1:0]}]
                <= {in_beat.num_key, in_beat.rec_id};
        if (cmd.rd_head) ckey_reg <= key_mem[{scan_reg, cslot}];
    end

    // text memory: two read addresses, cand/best or winner
    logic [TAW-1:0] ta_addr, tb_addr;
    always_comb begin
        ta_addr = {scan_reg, cslot, chk_reg};
        tb_addr = {brun_reg, bslot_reg, chk_reg};
    end
    always_ff @(posedge aclk) begin
        if (cmd.capture && in_beat.cmd == CMD_LOAD_TEXT
            && 32'(in_beat.run_index) < NUM_RUNS && 32'(in_beat.slot_index) < RECS_PER_RUN
            && 32'(in_beat.chunk_index) < TEXT_WORDS)
            txt_mem[{in_beat.run_index[RW-1:0], in_beat.slot_index[SW-1:0],
                     in_beat.chunk_index[CW-1:0]}] <= in_beat.text_chunk;
        if (cmd.rd_chunk) ta_reg <= txt_mem[ta_addr];
        if (cmd.rd_chunk || cmd.emit_rd) tb_reg <= txt_mem[tb_addr];
    end

    // key compare of candidate against best
    logic num_lt, num_eq, key_lt, need_text;
    always_comb begin
        num_lt = ckey_reg[63:32] < bkey_reg[63:32];
        num_eq = ckey_reg[63:32] == bkey_reg[63:32];
        case (key_mode)
            MODE_ID:   begin key_lt = ckey_reg[31:0] < bkey_reg[31:0]; need_text = 1'b0; end
            MODE_NUM:  begin key_lt = num_lt; need_text = 1'b0; end
            MODE_TEXT: begin key_lt = 1'b0;   need_text = 1'b1; end
            default:   begin key_lt = num_lt; need_text = num_eq; end
        endcase
    end

    // byte-wise chunk compare: 8 steps, first byte most significant
    logic c_lt, c_gt, c_zero;
    always_comb begin
        logic stop;
        stop = 1'b0; c_lt = 1'b0; c_gt = 1'b0; c_zero = 1'b0;
        for (int k = 7; k >= 0; k--) begin
            if (!stop) begin
                if (ta_reg[8*k +: 8] != tb_reg[8*k +: 8]) begin
                    stop = 1'b1;
                    c_lt = ta_reg[8*k +: 8] < tb_reg[8*k +: 8];
                    c_gt = !c_lt;
                end else if (ta_reg[8*k +: 8] == 8'd0) begin
                    stop = 1'b1;
                    c_zero = 1'b1;
                end
            end
        end
    end

    logic chunk_last;
    assign chunk_last = (32'(chk_reg) == TEXT_WORDS - 1);

    // take candidate as new best
    logic take;
    assign take = cmd.decide ? (!have_reg || key_lt)
                             : (cmd.step_chunk && c_lt);

    // result beat of a pop with no valid run
    out_beat_t empty_beat;
    always_comb begin
        empty_beat      = '0;
        empty_beat.last = 1'b1;
    end

    // control and run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            have_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_RUNS; i++) cur_reg[i] <= '0;
        end else begin
            if (cmd.capture && in_beat.cmd == CMD_ARM && 32'(in_beat.run_index) < NUM_RUNS) begin
                cur_reg[in_beat.run_index[RW-1:0]] <= '0;
                vld_reg[in_beat.run_index[RW-1:0]] <= 1'b1;
            end
            if (cmd.scan_start) have_reg <= 1'b0;
            if (take) have_reg <= 1'b1;
            if (cmd.commit) begin
                cur_reg[brun_reg] <= cur_reg[brun_reg] + CURW'(1);
                if (32'(cur_reg[brun_reg]) + 1 >= RECS_PER_RUN) vld_reg[brun_reg] <= 1'b0;
            end
            if (cmd.emit_load || cmd.emit_empty) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) ib_reg <= in_beat;
        if (cmd.scan_start) scan_reg <= '0;
        if (cmd.next_run)   scan_reg <= scan_reg + RW'(1);
        if (cmd.rd_head || cmd.commit) chk_reg <= '0;
        if (cmd.step_chunk) chk_reg <= chk_reg + CW'(1);
        if (cmd.emit_load) chk_reg <= chk_reg + CW'(1);
        if (take) begin
            brun_reg  <= scan_reg;
            bslot_reg <= cslot;
            bkey_reg  <= ckey_reg;
        end
        if (cmd.emit_load) begin
            m_data_reg.found           <= 1'b1;
            m_data_reg.win_run         <= 3'(brun_reg);
            m_data_reg.win_slot        <= 4'(bslot_reg);
            m_data_reg.out_id          <= bkey_reg[31:0];
            m_data_reg.out_num         <= bkey_reg[63:32];
            m_data_reg.out_chunk       <= tb_reg;
            m_data_reg.out_chunk_index <= 4'(chk_reg);
            m_data_reg.last            <= chunk_last;
        end
        if (cmd.emit_empty) m_data_reg <= empty_beat;
    end

    always_comb begin
        stat.is_pop     = ib_reg.cmd == CMD_POP;
        stat.cand_ok    = cand_ok;
        stat.have       = have_reg;
        stat.need_text  = need_text;
        stat.text_done  = c_lt || c_gt || c_zero;
        stat.scan_last  = (32'(scan_reg) == NUM_RUNS - 1);
        stat.chunk_last = chunk_last;
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_busy = m_valid_reg && !m_ready;

    a_take_have: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> have_reg)
        else $error("best not recorded");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output changed while stalled");
    a_commit_have: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> have_reg)
        else $error("commit without winner");
endmodule

// ===== hdl/kway_merge_min_select.sv =====
// Sequence: load/arm commands are captured and return to idle; a pop scans each
// run head, compares text by chunk, then emits TEXT_WORDS beats or an empty beat.
// Throughput: one item at a time; set by the chunk-serial text compare against
// the single text memory and the registered output beat.
// Reset: synchronous active-low aresetn clears run valid flags, cursors, key_mode
// and the sequencer; key and text memories hold undefined contents until written.
// ----------------------------------------------------------------------------
// kway_merge_min_select: top level
// K-way merge minimum selector with controller and datapath.
// ----------------------------------------------------------------------------
module kway_merge_min_select #(
    parameter int NUM_RUNS     = kmms_pkg::DEF_NUM_RUNS,
    parameter int RECS_PER_RUN = kmms_pkg::DEF_RECS_PER_RUN,
    parameter int TEXT_WORDS   = kmms_pkg::DEF_TEXT_WORDS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  kmms_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kmms_pkg::out_beat_t m_data
);
    import kmms_pkg::*;

    logic [1:0] key_mode_reg;
    dp_cmd_t    cmd;
    dp_stat_t   stat;
    logic       out_busy;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn)    key_mode_reg <= MODE_ID;
        else if (cfg_we) key_mode_reg <= cfg_wdata;
    end

    kmms_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_valid && s_ready),
        .out_busy(out_busy), .stat(stat), .s_ready_o(s_ready), .cmd(cmd)
    );

    kmms_dp #(
        .NUM_RUNS(NUM_RUNS), .RECS_PER_RUN(RECS_PER_RUN), .TEXT_WORDS(TEXT_WORDS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .key_mode(key_mode_reg), .in_beat(s_data),
        .cmd(cmd), .m_ready(m_ready), .stat(stat), .m_valid(m_valid),
        .m_data(m_data), .out_busy(out_busy)
    );
endmodule
